// ===== rtl/idsp_pkg.sv =====
package idsp_pkg;

    localparam int FIELD_W    = 32;
    localparam int NS_W       = 62;
    localparam int OUT_DATA_W = 224;
    localparam int OUT_USER_W = 2;

    localparam logic [29:0] NS_PER_S = 30'd1000000000;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_START,
        PH_AFTER_MINUS,
        PH_ITEM,
        PH_BLANKS,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [2:0] {
        DS_NONE,
        DS_Y,
        DS_M,
        DS_D,
        DS_W,
        DS_H,
        DS_S
    } t_desig;

    typedef struct packed {
        logic       is_blank;
        logic       is_digit;
        logic       is_plus;
        logic       is_minus;
        logic       is_p;
        logic       is_t;
        logic [3:0] digit;
        t_desig     desig;
    } t_char_class;

endpackage

// ===== rtl/iso_duration_stream_parser.sv =====
// ISO 8601 duration parser on a character stream.
//
// Slave channel: one character per request in s_axis_tdata, s_axis_tuser
// flags whether the character is present (a request with tuser low and
// tlast high is a bare end marker), s_axis_tlast closes the string.
// Master channel: one result per string, sent after the request that
// carried tlast. tuser holds ok and the sign, tdata the six components,
// with seconds scaled to nanoseconds. A failed parse gives all zeros.
//
// Throughput: one character per cycle, back to back, unless a result is
// held by a stalled receiver. Each character is handled by a single pass
// of decode, digit accumulate and saturate logic into the state registers;
// the seconds scaling multiplier sits in the result path. The result is
// registered and valid in the cycle after the tlast request is accepted.
//
// Reset clears the parser to "expect sign or P", zeroes the components and
// drops any pending result. When the receiver stalls with a result held,
// s_axis_tready goes low and the parser holds until the result is taken;
// after tlast the parser restarts for the next string at once.
module iso_duration_stream_parser #(
    parameter int FIELD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tuser,   // [0] has_char
    input  logic        s_axis_tlast,   // last
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] years, [63:32] months, [95:64] days, [127:96] hours,
    // [159:128] minutes, [221:160] nanoseconds, [223:222] zero
    output logic [idsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [idsp_pkg::OUT_USER_W-1:0] m_axis_tuser   // [0] ok, [1] negative
);
    import idsp_pkg::*;

    localparam int FB    = FIELD_BITS;
    localparam int FEXT  = (FB > FIELD_W) ? FB : FIELD_W;
    localparam int PW    = FB + 31;
    localparam int NSEXT = (PW > NS_W) ? PW : NS_W;

    localparam logic [FB-1:0]          FIELD_HI = {1'b0, {(FB-1){1'b1}}};
    localparam logic [FB-1:0]          FIELD_LO = {1'b1, {(FB-1){1'b0}}};
    localparam logic [FB+3:0]          MAG_CAP  = (FB+4)'(1) << (FB-1);
    localparam logic signed [FB+2:0]   W_HI     = (FB+3)'($signed(FIELD_HI));
    localparam logic signed [FB+2:0]   W_LO     = (FB+3)'($signed(FIELD_LO));

    function automatic logic [FIELD_W-1:0] to_field(input logic signed [FB-1:0] v);
        logic signed [FEXT-1:0] e;
        e = FEXT'(v);
        return e[FIELD_W-1:0];
    endfunction

    t_char_class cls;

    idsp_char_decode u_decode (
        .i_ch  (s_axis_tdata),
        .o_cls (cls)
    );

    // parser state
    t_phase                r_phase, n_phase;
    logic                  r_in_time, n_in_time;
    logic                  r_neg, n_neg;
    logic                  r_num_neg, n_num_neg;
    logic [FB-1:0]         r_acc, n_acc;
    logic signed [FB-1:0]  r_year, n_year;
    logic signed [FB-1:0]  r_month, n_month;
    logic signed [FB-1:0]  r_day, n_day;
    logic signed [FB-1:0]  r_hour, n_hour;
    logic signed [FB-1:0]  r_minute, n_minute;
    logic signed [FB-1:0]  r_sec, n_sec;

    // result register
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic                  r_out_neg;
    logic [FIELD_W-1:0]    r_out_year, r_out_month, r_out_day;
    logic [FIELD_W-1:0]    r_out_hour, r_out_minute;
    logic [NS_W-1:0]       r_out_ns;

    logic                  in_take;
    logic                  out_take;
    logic                  step_ok;

    // datapath helpers
    logic [FB+3:0]         dig_sum;
    logic [FB-1:0]         dig_next;
    logic [FB:0]           acc_neg;
    logic signed [FB-1:0]  des_val;
    logic signed [FB+2:0]  wk7;
    logic signed [FB-1:0]  wk_val;
    logic signed [PW-1:0]  ns_prod;
    logic signed [NSEXT-1:0] ns_ext;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    // accumulate a digit, capping the magnitude at 2^(FB-1)
    assign dig_sum  = (FB+4)'({r_acc, 3'b000}) + (FB+4)'({r_acc, 1'b0})
                    + (FB+4)'(cls.digit);
    assign dig_next = (dig_sum > MAG_CAP) ? MAG_CAP[FB-1:0] : dig_sum[FB-1:0];

    // signed value at a designator; only a positive magnitude at the cap clips
    assign acc_neg = -{1'b0, r_acc};
    assign des_val = r_num_neg ? $signed(acc_neg[FB-1:0])
                   : (r_acc[FB-1] ? $signed(FIELD_HI) : $signed(r_acc));

    // weeks to days, saturated
    assign wk7    = ((FB+3)'(des_val) <<< 3) - (FB+3)'(des_val);
    assign wk_val = (wk7 > W_HI) ? $signed(FIELD_HI)
                  : (wk7 < W_LO) ? $signed(FIELD_LO) : $signed(wk7[FB-1:0]);

    // next state for one character
    always_comb begin
        n_phase   = r_phase;
        n_in_time = r_in_time;
        n_neg     = r_neg;
        n_num_neg = r_num_neg;
        n_acc     = r_acc;
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_sec     = r_sec;
        if (s_axis_tuser) begin
            unique case (r_phase) inside
                PH_START: begin
                    if (cls.is_minus) begin
                        n_neg   = 1'b1;
                        n_phase = PH_AFTER_MINUS;
                    end else if (cls.is_p) begin
                        n_phase = PH_ITEM;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_AFTER_MINUS: begin
                    n_phase = cls.is_p ? PH_ITEM : PH_ERROR;
                end
                PH_ITEM, PH_BLANKS: begin
                    n_num_neg = 1'b0;
                    // a T in the item phase (not after blanks) only sets the time mark
                    if (r_phase == PH_ITEM && cls.is_t) begin
                        n_in_time = 1'b1;
                    end else if (cls.is_blank) begin
                        n_phase = PH_BLANKS;
                    end else if (cls.is_plus || cls.is_minus) begin
                        n_num_neg = cls.is_minus;
                        n_phase   = PH_SIGN;
                    end else if (cls.is_digit) begin
                        n_acc   = FB'(cls.digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGN: begin
                    if (cls.is_digit) begin
                        n_acc   = FB'(cls.digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (cls.is_digit) begin
                        n_acc = dig_next;
                    end else begin
                        n_phase = PH_ITEM;
                        case (cls.desig)
                            DS_Y: begin
                                if (!r_in_time) n_year = des_val;
                                else            n_phase = PH_ERROR;
                            end
                            DS_M: begin
                                if (!r_in_time) n_month  = des_val;
                                else            n_minute = des_val;
                            end
                            DS_D: begin
                                if (!r_in_time) n_day = des_val;
                                else            n_phase = PH_ERROR;
                            end
                            DS_W: begin
                                if (!r_in_time) n_day = wk_val;
                                else            n_phase = PH_ERROR;
                            end
                            DS_H: begin
                                if (r_in_time) n_hour = des_val;
                                else           n_phase = PH_ERROR;
                            end
                            DS_S: begin
                                if (r_in_time) n_sec = des_val;
                                else           n_phase = PH_ERROR;
                            end
                            default: n_phase = PH_ERROR;
                        endcase
                    end
                end
                default: begin
                    // done or error: drop characters until the end marker
                end
            endcase
        end
    end

    assign step_ok = (n_phase == PH_ITEM) || (n_phase == PH_BLANKS)
                  || (n_phase == PH_SIGN) || (n_phase == PH_DONE);

    // seconds to nanoseconds
    assign ns_prod = n_sec * $signed({1'b0, NS_PER_S});
    assign ns_ext  = NSEXT'(ns_prod);

    // state register; restart after the end marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_in_time <= 1'b0;
            r_neg     <= 1'b0;
            r_num_neg <= 1'b0;
            r_acc     <= '0;
            r_year    <= '0;
            r_month   <= '0;
            r_day     <= '0;
            r_hour    <= '0;
            r_minute  <= '0;
            r_sec     <= '0;
        end else if (in_take) begin
            if (s_axis_tlast) begin
                r_phase   <= PH_START;
                r_in_time <= 1'b0;
                r_neg     <= 1'b0;
                r_num_neg <= 1'b0;
                r_acc     <= '0;
                r_year    <= '0;
                r_month   <= '0;
                r_day     <= '0;
                r_hour    <= '0;
                r_minute  <= '0;
                r_sec     <= '0;
            end else begin
                r_phase   <= n_phase;
                r_in_time <= n_in_time;
                r_neg     <= n_neg;
                r_num_neg <= n_num_neg;
                r_acc     <= n_acc;
                r_year    <= n_year;
                r_month   <= n_month;
                r_day     <= n_day;
                r_hour    <= n_hour;
                r_minute  <= n_minute;
                r_sec     <= n_sec;
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload; a failed parse reports zeros
    always_ff @(posedge i_clk) begin
        if (in_take && s_axis_tlast) begin
            r_out_ok     <= step_ok;
            r_out_neg    <= step_ok && n_neg;
            r_out_year   <= step_ok ? to_field(n_year)   : '0;
            r_out_month  <= step_ok ? to_field(n_month)  : '0;
            r_out_day    <= step_ok ? to_field(n_day)    : '0;
            r_out_hour   <= step_ok ? to_field(n_hour)   : '0;
            r_out_minute <= step_ok ? to_field(n_minute) : '0;
            r_out_ns     <= step_ok ? ns_ext[NS_W-1:0]   : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out_neg, r_out_ok};
    assign m_axis_tdata  = {(OUT_DATA_W - NS_W - 5*FIELD_W)'(0), r_out_ns, r_out_minute,
                            r_out_hour, r_out_day, r_out_month, r_out_year};

endmodule

// ===== rtl/idsp_char_decode.sv =====
module idsp_char_decode (
    input  logic [7:0]           i_ch,
    output idsp_pkg::t_char_class o_cls
);
    import idsp_pkg::*;

    always_comb begin
        o_cls.is_blank = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);
        o_cls.is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        o_cls.is_plus  = (i_ch == CH_PLUS);
        o_cls.is_minus = (i_ch == CH_MINUS);
        o_cls.is_p     = (i_ch == CH_P);
        o_cls.is_t     = (i_ch == CH_T);
        // low nibble of '0'..'9' is the digit value
        o_cls.digit    = i_ch[3:0];
        unique case (i_ch)
            CH_Y:    o_cls.desig = DS_Y;
            CH_M:    o_cls.desig = DS_M;
            CH_D:    o_cls.desig = DS_D;
            CH_W:    o_cls.desig = DS_W;
            CH_H:    o_cls.desig = DS_H;
            CH_S:    o_cls.desig = DS_S;
            default: o_cls.desig = DS_NONE;
        endcase
    end

endmodule
